FILE: rtl/slms_pkg.sv
// ----------------------------------------------------------------------------
// Status LED mode sequencer package
// Shared codes and the state record of the status LED sequencer.
// ----------------------------------------------------------------------------
package slms_pkg;

   typedef enum logic [2:0] {
      MODE_OFF    = 3'd0,
      MODE_SOLID  = 3'd1,
      MODE_BLINK  = 3'd2,
      MODE_CHARGE = 3'd3,
      MODE_LOWBAT = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_PROFILE  = 3'd1,
      OP_ACTIVITY = 3'd2,
      OP_USB      = 3'd3,
      OP_BATTERY  = 3'd4
   } op_type;

   localparam logic [1:0] ACT_ACTIVE = 2'd0;
   localparam logic [1:0] ACT_SLEEP  = 2'd2;

   localparam logic [1:0] CSR_PROFILE_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_BLINK_INTERVAL  = 2'd1;
   localparam logic [1:0] CSR_LOWBAT_LEVEL    = 2'd2;
   localparam logic [1:0] CSR_LOWBAT_FLASHES  = 2'd3;

   localparam logic [15:0] PROFILE_TIMEOUT_RESET = 16'd3000;
   localparam logic [15:0] BLINK_INTERVAL_RESET  = 16'd250;
   localparam logic [6:0]  LOWBAT_LEVEL_RESET    = 7'd15;
   localparam logic [2:0]  LOWBAT_FLASHES_RESET  = 3'd3;
   localparam logic [6:0]  BATTERY_FULL          = 7'd100;

   localparam logic [2:0] LED_NONE   = 3'b000;
   localparam logic [2:0] LED_CHARGE = 3'b100;
   localparam logic [2:0] LED_ALL    = 3'b111;
   localparam logic [2:0] FLASH_MAX  = 3'd7;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] wait_count;
      logic        timer_armed;
      logic        blink_phase;
      logic [2:0]  flash_count;
      logic [2:0]  profile_index;
      logic        profile_pairing;
      logic        usb_power;
      logic        asleep;
      logic [6:0]  previous_battery;
      logic [2:0]  led_drive;
   } state_type;

endpackage

FILE: rtl/status_led_mode_sequencer.sv
// ----------------------------------------------------------------------------
// Status LED mode sequencer
// Steps three indicator LEDs through off, profile, pairing, charging and
// low-battery modes from millisecond ticks and system events.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  operation and event fields
//   rsp      out        rsp_valid/rsp_stall  led_mask, mode
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// An item is registered on entry and then processed into the result
// register; one item is taken per cycle while the result is not stalled.
// The state update of each item is a single combinational pass. Reset
// clears the valid flags and loads the state and register defaults; the
// input and result fields are not reset. A stalled result holds the
// processing stage; one more item waits in the input register.
// ----------------------------------------------------------------------------
module status_led_mode_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [2:0]  req_profile_number,
   input  logic        req_pairing_open,
   input  logic [1:0]  req_activity_state,
   input  logic        req_usb_connected,
   input  logic        req_charger_active,
   input  logic [6:0]  req_battery_percent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_led_mask,
   output logic [2:0]  rsp_mode,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   logic [15:0] profile_timeout_ff;
   logic [15:0] blink_interval_ff;
   logic [6:0]  lowbat_level_ff;
   logic [2:0]  lowbat_flashes_ff;

   logic        in_valid_ff;
   logic [2:0]  operation_ff;
   logic [2:0]  profile_number_ff;
   logic        pairing_open_ff;
   logic [1:0]  activity_state_ff;
   logic        usb_connected_ff;
   logic        charger_active_ff;
   logic [6:0]  battery_percent_ff;

   slms_pkg::state_type state_ff;
   slms_pkg::state_type state_in;

   logic        rsp_valid_ff;
   logic [2:0]  led_mask_ff;
   logic [2:0]  rsp_mode_ff;

   logic        process;

   function automatic logic [15:0] wait_of(input logic [15:0] ms);
      return (ms == 16'd0) ? 16'd1 : ms;
   endfunction

   function automatic slms_pkg::state_type animate(
      input slms_pkg::state_type st_arg,
      input logic                pairing_now,
      input logic                charging_now,
      input logic [15:0]         interval,
      input logic [2:0]          flashes
   );
      slms_pkg::state_type st;
      logic                do_arm;
      logic [2:0]          pattern;
      st      = st_arg;
      do_arm  = 1'b0;
      pattern = st.profile_index + 3'd1;
      if (st.asleep) begin
         st.led_drive = slms_pkg::LED_NONE;
      end else begin
         unique case (st.mode)
            slms_pkg::MODE_SOLID: begin
               if (st.profile_pairing) begin
                  st.mode        = slms_pkg::MODE_BLINK;
                  st.blink_phase = 1'b1;
                  do_arm         = 1'b1;
               end else if (st.usb_power && charging_now) begin
                  st.mode        = slms_pkg::MODE_CHARGE;
                  st.blink_phase = 1'b1;
                  do_arm         = 1'b1;
               end else begin
                  st.mode      = slms_pkg::MODE_OFF;
                  st.led_drive = slms_pkg::LED_NONE;
               end
            end
            slms_pkg::MODE_BLINK: begin
               st.profile_pairing = pairing_now;
               if (!pairing_now) begin
                  if (st.usb_power && charging_now) begin
                     st.mode        = slms_pkg::MODE_CHARGE;
                     st.blink_phase = 1'b1;
                     do_arm         = 1'b1;
                  end else begin
                     st.mode      = slms_pkg::MODE_OFF;
                     st.led_drive = slms_pkg::LED_NONE;
                  end
               end else begin
                  st.blink_phase = !st.blink_phase;
                  st.led_drive   = st.blink_phase ? pattern : slms_pkg::LED_NONE;
                  do_arm         = 1'b1;
               end
            end
            slms_pkg::MODE_CHARGE: begin
               if (!st.usb_power) begin
                  st.mode      = slms_pkg::MODE_OFF;
                  st.led_drive = slms_pkg::LED_NONE;
               end else begin
                  st.blink_phase = !st.blink_phase;
                  st.led_drive   = (st.blink_phase && charging_now) ?
                                   slms_pkg::LED_CHARGE : slms_pkg::LED_NONE;
                  do_arm         = 1'b1;
               end
            end
            slms_pkg::MODE_LOWBAT: begin
               st.blink_phase = !st.blink_phase;
               if (st.blink_phase) begin
                  st.led_drive = slms_pkg::LED_ALL;
                  if (st.flash_count < slms_pkg::FLASH_MAX) begin
                     st.flash_count = st.flash_count + 3'd1;
                  end
               end else begin
                  st.led_drive = slms_pkg::LED_NONE;
               end
               if (st.flash_count >= flashes) begin
                  st.mode      = slms_pkg::MODE_OFF;
                  st.led_drive = slms_pkg::LED_NONE;
               end else begin
                  do_arm = 1'b1;
               end
            end
            default: begin
               st.led_drive = slms_pkg::LED_NONE;
            end
         endcase
      end
      if (do_arm) begin
         st.wait_count  = wait_of(interval);
         st.timer_armed = 1'b1;
      end
      return st;
   endfunction

   function automatic slms_pkg::state_type start(
      input slms_pkg::state_type st_arg,
      input slms_pkg::mode_type  new_mode,
      input logic                pairing_now,
      input logic                charging_now,
      input logic [15:0]         timeout,
      input logic [15:0]         interval,
      input logic [2:0]          flashes
   );
      slms_pkg::state_type st;
      st = st_arg;
      if (!st.asleep) begin
         st.timer_armed = 1'b0;
         st.mode        = new_mode;
         st.blink_phase = 1'b1;
         st.flash_count = 3'd0;
         if (new_mode == slms_pkg::MODE_SOLID) begin
            st.led_drive   = st.profile_index + 3'd1;
            st.wait_count  = wait_of(timeout);
            st.timer_armed = 1'b1;
         end else begin
            st = animate(st, pairing_now, charging_now, interval, flashes);
         end
      end
      return st;
   endfunction

   assign process   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !process;

   always_comb begin
      state_in = state_ff;
      unique case (operation_ff)
         slms_pkg::OP_TICK: begin
            if (state_ff.timer_armed) begin
               if (state_ff.wait_count <= 16'd1) begin
                  state_in.wait_count  = 16'd0;
                  state_in.timer_armed = 1'b0;
                  state_in = animate(state_in, pairing_open_ff, charger_active_ff,
                                     blink_interval_ff, lowbat_flashes_ff);
               end else begin
                  state_in.wait_count = state_ff.wait_count - 16'd1;
               end
            end
         end
         slms_pkg::OP_PROFILE: begin
            state_in.profile_index   = profile_number_ff;
            state_in.profile_pairing = pairing_open_ff;
            state_in = start(state_in, slms_pkg::MODE_SOLID, pairing_open_ff,
                             charger_active_ff, profile_timeout_ff,
                             blink_interval_ff, lowbat_flashes_ff);
         end
         slms_pkg::OP_ACTIVITY: begin
            if (activity_state_ff == slms_pkg::ACT_SLEEP) begin
               state_in.asleep      = 1'b1;
               state_in.timer_armed = 1'b0;
               state_in.wait_count  = 16'd0;
               state_in.led_drive   = slms_pkg::LED_NONE;
            end else if (activity_state_ff == slms_pkg::ACT_ACTIVE) begin
               state_in.asleep = 1'b0;
            end
         end
         slms_pkg::OP_USB: begin
            state_in.usb_power = usb_connected_ff;
            if (!state_ff.asleep) begin
               if (usb_connected_ff && !state_ff.usb_power &&
                   state_ff.mode == slms_pkg::MODE_OFF) begin
                  if (charger_active_ff) begin
                     state_in = start(state_in, slms_pkg::MODE_CHARGE, pairing_open_ff,
                                      charger_active_ff, profile_timeout_ff,
                                      blink_interval_ff, lowbat_flashes_ff);
                  end
               end else if (!usb_connected_ff &&
                            state_ff.mode == slms_pkg::MODE_CHARGE) begin
                  state_in.mode      = slms_pkg::MODE_OFF;
                  state_in.led_drive = slms_pkg::LED_NONE;
               end
            end
         end
         slms_pkg::OP_BATTERY: begin
            if (battery_percent_ff <= lowbat_level_ff &&
                state_ff.previous_battery > lowbat_level_ff &&
                !state_ff.asleep && !state_ff.usb_power) begin
               state_in = start(state_in, slms_pkg::MODE_LOWBAT, pairing_open_ff,
                                charger_active_ff, profile_timeout_ff,
                                blink_interval_ff, lowbat_flashes_ff);
            end
            state_in.previous_battery = battery_percent_ff;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_timeout_ff <= slms_pkg::PROFILE_TIMEOUT_RESET;
         blink_interval_ff  <= slms_pkg::BLINK_INTERVAL_RESET;
         lowbat_level_ff    <= slms_pkg::LOWBAT_LEVEL_RESET;
         lowbat_flashes_ff  <= slms_pkg::LOWBAT_FLASHES_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            slms_pkg::CSR_PROFILE_TIMEOUT: profile_timeout_ff <= csr_write_data;
            slms_pkg::CSR_BLINK_INTERVAL:  blink_interval_ff  <= csr_write_data;
            slms_pkg::CSR_LOWBAT_LEVEL:    lowbat_level_ff    <= csr_write_data[6:0];
            slms_pkg::CSR_LOWBAT_FLASHES:  lowbat_flashes_ff  <= csr_write_data[2:0];
            default: begin
               lowbat_flashes_ff <= lowbat_flashes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                <= 1'b0;
         rsp_valid_ff               <= 1'b0;
         state_ff.mode              <= slms_pkg::MODE_OFF;
         state_ff.wait_count        <= 16'd0;
         state_ff.timer_armed       <= 1'b0;
         state_ff.blink_phase       <= 1'b0;
         state_ff.flash_count       <= 3'd0;
         state_ff.profile_index     <= 3'd0;
         state_ff.profile_pairing   <= 1'b0;
         state_ff.usb_power         <= 1'b0;
         state_ff.asleep            <= 1'b0;
         state_ff.previous_battery  <= slms_pkg::BATTERY_FULL;
         state_ff.led_drive         <= slms_pkg::LED_NONE;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (process) begin
            in_valid_ff <= 1'b0;
         end
         if (process) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         operation_ff       <= req_operation;
         profile_number_ff  <= req_profile_number;
         pairing_open_ff    <= req_pairing_open;
         activity_state_ff  <= req_activity_state;
         usb_connected_ff   <= req_usb_connected;
         charger_active_ff  <= req_charger_active;
         battery_percent_ff <= req_battery_percent;
      end
      if (process) begin
         led_mask_ff <= state_in.led_drive;
         rsp_mode_ff <= state_in.mode;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_led_mask = led_mask_ff;
   assign rsp_mode     = rsp_mode_ff;

endmodule
